// ===== sv/rmv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_pkg: shared types and constants for running_mean_variance
// Fixed-point widths, transfer structs and the request/response structs of
// the shared divider and the partial-product multiplier.
// ----------------------------------------------------------------------------
package rmv_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int COUNT_BITS  = 32;
	localparam int VAR_BITS    = 64;

	localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;
	localparam int DIFF_BITS = MEAN_BITS + 1;
	localparam int LO_BITS   = (DIFF_BITS + 1) / 2;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int WIDE_BITS = (PROD_BITS > VAR_BITS + FRAC_BITS) ? PROD_BITS
		: VAR_BITS + FRAC_BITS + 1;
	localparam int STEP_BITS = $clog2(VAR_BITS + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [MEAN_BITS-1:0]   mean_t;
	typedef logic signed [DIFF_BITS-1:0]   diff_t;
	typedef logic [DIFF_BITS-1:0]          mag_t;
	typedef logic [COUNT_BITS-1:0]         count_t;
	typedef logic [VAR_BITS-1:0]           var_t;
	typedef logic [LO_BITS-1:0]            half_t;
	typedef logic [PROD_BITS-1:0]          prod_t;
	typedef logic [WIDE_BITS-1:0]          wide_t;
	typedef logic [STEP_BITS-1:0]          step_t;

	localparam count_t COUNT_MAX      = '1;
	localparam step_t  DIV_MEAN_STEPS = step_t'(DIFF_BITS);
	localparam step_t  DIV_VAR_STEPS  = step_t'(VAR_BITS);

	// multiplier sequence: four partial products, then a flush step
	localparam logic [2:0] MUL_LAST_IDX = 3'd4;

	typedef struct packed {
		sample_t sample;
		logic    restart;
	} item_t;

	typedef struct packed {
		count_t  total;
		sample_t minimum;
		sample_t maximum;
		mean_t   mean_value;
		var_t    variance_value;
		logic    variance_valid;
	} stat_t;

	typedef struct packed {
		logic   start;
		step_t  steps;
		var_t   dividend;
		count_t divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		var_t quotient;
	} div_rsp_t;

	typedef struct packed {
		logic start;
		mag_t a;
		mag_t b;
	} mul_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		prod_t product;
	} mul_rsp_t;

	function automatic mag_t mag_of(diff_t d);
		mag_t m;
		m = d[DIFF_BITS-1] ? mag_t'(-d) : mag_t'(d);
		return m;
	endfunction

endpackage

// ===== sv/running_mean_variance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_variance: running count, min, max, mean and sample variance
// Welford update in fixed point, sequenced over a shared serial divider and
// a partial-product multiplier.
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// item     in   item_valid/item_stall   item_data (sample, restart)
// stat     out  stat_valid/stat_stall   stat_data (total .. variance_valid)
//
// First sample of a run: the result is loaded straight from the done state,
// once the output is free. Other samples: the mean step on the divider, the
// second difference, the multiplier, then the variance step on the divider.
// item_stall is high from transfer until the result is loaded.
// A result held by stat_stall keeps the next result in the sequencer.
// Reset clears the count, so the next sample starts a new run.
// ----------------------------------------------------------------------------
module running_mean_variance import rmv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item_data,
	output logic  stat_valid,
	input  logic  stat_stall,
	output stat_t stat_data
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIVM = 7'b0000010,
		ST_DIFF = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_VGO  = 7'b0010000,
		ST_DIVV = 7'b0100000,
		ST_DONE = 7'b1000000
	} seq_state_t;

	seq_state_t state_q;
	count_t     count_q;
	sample_t    low_q;
	sample_t    high_q;
	mean_t      mean_q;
	var_t       m2_q;
	sample_t    x_q;
	diff_t      d1_q;
	var_t       var_q;
	logic       vvalid_q;
	stat_t      stat_q;
	logic       stat_valid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic               accept;
	logic               first_in;
	count_t             n_in;
	mean_t              xs_in;
	diff_t              d1_in;
	mean_t              xs_q;
	diff_t              d2;
	mean_t              quo_m;
	wide_t              wide;
	logic               term_sat;
	var_t               term;
	logic [VAR_BITS:0]  m2_sum;
	var_t               m2_next;
	logic               load_out;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign first_in   = item_data.restart || (count_q == '0);
	assign n_in       = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	assign xs_in = {item_data.sample, {FRAC_BITS{1'b0}}};
	assign d1_in = {xs_in[MEAN_BITS-1], xs_in} - {mean_q[MEAN_BITS-1], mean_q};
	assign xs_q  = {x_q, {FRAC_BITS{1'b0}}};
	assign d2    = {xs_q[MEAN_BITS-1], xs_q} - {mean_q[MEAN_BITS-1], mean_q};
	assign quo_m = mean_t'(div_rsp.quotient[MEAN_BITS-1:0]);

	assign wide     = wide_t'(mul_rsp.product);
	assign term_sat = |wide[WIDE_BITS-1:VAR_BITS+FRAC_BITS];
	assign term     = term_sat ? '1 : wide[VAR_BITS+FRAC_BITS-1:FRAC_BITS];
	assign m2_sum   = {1'b0, m2_q} + {1'b0, term};
	assign m2_next  = m2_sum[VAR_BITS] ? '1 : m2_sum[VAR_BITS-1:0];

	assign load_out = (state_q == ST_DONE) && (!stat_valid_q || !stat_stall);

	always_comb begin
		div_req = '0;
		if (accept && !first_in) begin
			div_req.start    = 1'b1;
			div_req.steps    = DIV_MEAN_STEPS;
			div_req.dividend = var_t'(mag_of(d1_in)) << (VAR_BITS - DIFF_BITS);
			div_req.divisor  = n_in;
		end else if (state_q == ST_VGO) begin
			div_req.start    = 1'b1;
			div_req.steps    = DIV_VAR_STEPS;
			div_req.dividend = m2_q;
			div_req.divisor  = count_q - 1'b1;
		end
	end

	always_comb begin
		mul_req.start = (state_q == ST_DIFF);
		mul_req.a     = mag_of(d1_q);
		mul_req.b     = mag_of(d2);
	end

	rmv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rmv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			stat_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				stat_valid_q <= 1'b1;
			end else if (!stat_stall) begin
				stat_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= first_in ? count_t'(1) : n_in;
						state_q <= first_in ? ST_DONE : ST_DIVM;
					end
				end
				ST_DIVM: begin
					if (div_rsp.done) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL: begin
					if (mul_rsp.done) begin
						state_q <= ST_VGO;
					end
				end
				ST_VGO: state_q <= ST_DIVV;
				ST_DIVV: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= item_data.sample;
			d1_q <= d1_in;
			if (first_in) begin
				low_q    <= item_data.sample;
				high_q   <= item_data.sample;
				mean_q   <= xs_in;
				m2_q     <= '0;
				var_q    <= '0;
				vvalid_q <= 1'b0;
			end else begin
				if (item_data.sample < low_q) begin
					low_q <= item_data.sample;
				end
				if (item_data.sample > high_q) begin
					high_q <= item_data.sample;
				end
			end
		end
		if (state_q == ST_DIVM && div_rsp.done) begin
			mean_q <= d1_q[DIFF_BITS-1] ? mean_q - quo_m : mean_q + quo_m;
		end
		if (state_q == ST_MUL && mul_rsp.done) begin
			m2_q <= m2_next;
		end
		if (state_q == ST_DIVV && div_rsp.done) begin
			var_q    <= div_rsp.quotient;
			vvalid_q <= 1'b1;
		end
		if (load_out) begin
			stat_q.total          <= count_q;
			stat_q.minimum        <= low_q;
			stat_q.maximum        <= high_q;
			stat_q.mean_value     <= mean_q;
			stat_q.variance_value <= var_q;
			stat_q.variance_valid <= vvalid_q;
		end
	end

	assign stat_valid = stat_valid_q;
	assign stat_data  = stat_q;

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid |-> stat_data.total != '0)
		else $error("result with zero count");

	a_valid_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid && stat_data.variance_valid |-> stat_data.total >= count_t'(2))
		else $error("variance flagged valid with fewer than two samples");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid |-> stat_data.minimum <= stat_data.maximum)
		else $error("minimum above maximum");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_rsp.busy && !mul_rsp.busy)
		else $error("arithmetic unit busy while sequencer idle");

endmodule

// ===== sv/rmv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_div: shared restoring divider
// One quotient bit per cycle; the caller picks the step count and
// left-aligns the dividend so the quotient lands in the low bits.
// ----------------------------------------------------------------------------
module rmv_div import rmv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	count_t                div_q;
	count_t                rem_q;
	var_t                  quo_q;
	step_t                 cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS+1:0] diff;
	logic                  fits;

	assign trial = {rem_q, quo_q[VAR_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign fits  = !diff[COUNT_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == step_t'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[VAR_BITS-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== sv/rmv_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_mul: partial-product multiplier
// Splits both magnitudes in halves, one half-width product per cycle into a
// product register, accumulated with its weight on the next cycle.
// ----------------------------------------------------------------------------
module rmv_mul import rmv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	mag_t                   a_q;
	mag_t                   b_q;
	logic [2:0]             idx_q;
	logic                   busy_q;
	logic                   done_q;
	logic                   part_vld_s1;
	logic [2*LO_BITS-1:0]   part_s1;
	logic [1:0]             pair_s1;
	prod_t                  acc_q;
	half_t                  op_a;
	half_t                  op_b;
	prod_t                  part_ext;
	prod_t                  weighted;

	assign op_a = idx_q[1] ? half_t'(a_q[DIFF_BITS-1:LO_BITS]) : a_q[LO_BITS-1:0];
	assign op_b = idx_q[0] ? half_t'(b_q[DIFF_BITS-1:LO_BITS]) : b_q[LO_BITS-1:0];
	assign part_ext = prod_t'(part_s1);

	always_comb begin
		case (pair_s1)
			2'd0:       weighted = part_ext;
			2'd1, 2'd2: weighted = part_ext << LO_BITS;
			2'd3:       weighted = part_ext << (2 * LO_BITS);
			default:    weighted = part_ext;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			idx_q       <= '0;
			part_vld_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q      <= 1'b1;
				idx_q       <= '0;
				part_vld_s1 <= 1'b0;
			end else if (busy_q) begin
				idx_q       <= idx_q + 1'b1;
				part_vld_s1 <= (idx_q != MUL_LAST_IDX);
				if (idx_q == MUL_LAST_IDX) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			part_s1 <= op_a * op_b;
			pair_s1 <= idx_q[1:0];
			if (part_vld_s1) begin
				acc_q <= acc_q + weighted;
			end
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule
